// ----- src/assert_macros.svh -----
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define DSPC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DSPC_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define DSPC_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// ----- src/dspc_pkg.sv -----
`timescale 1ns / 1ps

package dspc_pkg;

    localparam logic [2:0] REQ_POLL       = 3'd0;
    localparam logic [2:0] REQ_PIN_WAKE   = 3'd1;
    localparam logic [2:0] REQ_BUTTON     = 3'd2;
    localparam logic [2:0] REQ_FEEDBACK   = 3'd3;
    localparam logic [2:0] REQ_SLEEP_DONE = 3'd4;

    localparam logic [1:0] CFG_GRACE    = 2'd0;
    localparam logic [1:0] CFG_INPUT    = 2'd1;
    localparam logic [1:0] CFG_FEEDBACK = 2'd2;

    localparam logic [15:0] GRACE_MS_RST          = 16'd1500;
    localparam logic [15:0] INPUT_AWAKE_MS_RST    = 16'd700;
    localparam logic [15:0] FEEDBACK_AWAKE_MS_RST = 16'd2300;
    localparam logic [31:0] LAST_SECOND_RST       = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ACT_AWAKE      = 2'd0,
        ACT_POWER_SAVE = 2'd1,
        ACT_IDLE       = 2'd2
    } dspc_action_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] now_ms;
        logic [31:0] now_second;
        logic        local_mode;
        logic        gps_on;
        logic        timer_busy;
        logic        stopwatch_running;
        logic        edit_active;
        logic        fade_active;
    } dspc_in_t;

    typedef struct packed {
        dspc_action_t action;
        logic         update_display;
    } dspc_out_t;

    typedef struct packed {
        logic [15:0] grace_ms;
        logic [15:0] input_awake_ms;
        logic [15:0] feedback_awake_ms;
    } dspc_cfg_t;

    typedef struct packed {
        logic        armed;
        logic        pending_wake;
        logic [31:0] enter_time;
        logic [31:0] awake_until;
        logic [31:0] last_shown_second;
    } dspc_state_t;

    localparam dspc_state_t STATE_RST = '{
        armed:             1'b0,
        pending_wake:      1'b0,
        enter_time:        32'd0,
        awake_until:       32'd0,
        last_shown_second: LAST_SECOND_RST
    };

endpackage

// ----- src/dspc_policy.sv -----
`timescale 1ns / 1ps

module dspc_policy
    import dspc_pkg::*;
(
    input  dspc_cfg_t   cfg,
    input  dspc_state_t state_cur,
    input  dspc_in_t    item,
    output dspc_state_t state_next,
    output dspc_out_t   result
);

    logic        desk_ok;
    logic [31:0] enter_eff;
    logic [31:0] elapsed;
    logic [31:0] deadline_diff;
    logic [31:0] input_deadline;
    logic [31:0] feedback_deadline;

    assign desk_ok = item.local_mode && !item.gps_on && !item.timer_busy &&
                     !item.stopwatch_running && !item.edit_active && !item.fade_active;

    assign enter_eff         = state_cur.armed ? state_cur.enter_time : item.now_ms;
    assign elapsed           = item.now_ms - enter_eff;
    assign deadline_diff     = item.now_ms - state_cur.awake_until;
    assign input_deadline    = item.now_ms + {16'd0, cfg.input_awake_ms};
    assign feedback_deadline = item.now_ms + {16'd0, cfg.feedback_awake_ms};

    always_comb begin
        state_next            = state_cur;
        result.action         = ACT_AWAKE;
        result.update_display = 1'b0;
        unique case (item.req_type)
            REQ_POLL: begin
                if (!desk_ok) begin
                    state_next    = STATE_RST;
                    result.action = ACT_IDLE;
                end else begin
                    // arm on first qualifying poll
                    if (!state_cur.armed) begin
                        state_next.armed             = 1'b1;
                        state_next.enter_time        = item.now_ms;
                        state_next.last_shown_second = item.now_second;
                    end
                    priority if (elapsed < {16'd0, cfg.grace_ms}) begin
                        result.action = ACT_AWAKE;
                    end else if (state_cur.pending_wake) begin
                        state_next.pending_wake = 1'b0;
                        state_next.awake_until  = input_deadline;
                        result.action           = ACT_AWAKE;
                    end else if (deadline_diff[31]) begin
                        result.action = ACT_AWAKE;
                    end else begin
                        result.action = ACT_POWER_SAVE;
                    end
                end
            end
            REQ_PIN_WAKE: begin
                state_next.pending_wake = 1'b1;
            end
            REQ_BUTTON: begin
                state_next.awake_until = input_deadline;
            end
            REQ_FEEDBACK: begin
                state_next.awake_until = feedback_deadline;
            end
            REQ_SLEEP_DONE: begin
                if (item.now_second != state_cur.last_shown_second) begin
                    state_next.last_shown_second = item.now_second;
                    result.update_display        = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- src/desk_sleep_policy_controller.sv -----
`timescale 1ns / 1ps
// Desk sleep policy controller.
// Input channel s_valid/s_ready/s_data carries one request word per main-loop
// event (poll, pin wake, button, timestamp feedback, sleep done) with the
// millisecond and second counters and the activity flags. Every request word
// yields exactly one result word on m_valid/m_ready/m_data: the sleep action
// and the display refresh flag.
// The three window registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high. Write them while no
// request is in flight.
// A request accepted into the input register is decided from that register
// and its result is loaded into the result register and shown on m_valid.
// Throughput: one request per cycle while the receiver takes results; the
// decision is combinational subtracts, compares and adds on 32 bits between
// the two registers, and the policy state updates as the result is loaded.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more request; s_ready drops only when both hold.
// Reset (aresetn low, synchronous) empties both registers, disarms the
// policy and restores the default windows of 1500, 700 and 2300 ms.
`include "assert_macros.svh"

module desk_sleep_policy_controller
    import dspc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  dspc_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output dspc_out_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic        in_valid_reg;
    dspc_in_t    in_data_reg;
    logic        out_valid_reg;
    dspc_out_t   out_data_reg;
    dspc_state_t st_reg;
    dspc_state_t st_next;
    dspc_cfg_t   cfg_reg;
    dspc_out_t   res_next;
    logic        adv;

    assign adv       = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || adv;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    dspc_policy u_policy (
        .cfg        (cfg_reg),
        .state_cur  (st_reg),
        .item       (in_data_reg),
        .state_next (st_next),
        .result     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= STATE_RST;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (adv) begin
            out_data_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grace_ms          <= GRACE_MS_RST;
            cfg_reg.input_awake_ms    <= INPUT_AWAKE_MS_RST;
            cfg_reg.feedback_awake_ms <= FEEDBACK_AWAKE_MS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_GRACE:    cfg_reg.grace_ms          <= cfg_data;
                CFG_INPUT:    cfg_reg.input_awake_ms    <= cfg_data;
                CFG_FEEDBACK: cfg_reg.feedback_awake_ms <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    `DSPC_ASSERT(a_in_hold, aclk, aresetn, (in_valid_reg && !adv) |=> (in_valid_reg && $stable(in_data_reg)), "input word lost while result stalled")
    `DSPC_ASSERT(a_sleep_armed, aclk, aresetn, (adv && res_next.action == ACT_POWER_SAVE) |=> st_reg.armed, "power-save without armed policy")
    `DSPC_ASSERT(a_idle_clears, aclk, aresetn, (adv && res_next.action == ACT_IDLE) |=> (!st_reg.armed && !st_reg.pending_wake), "idle decision left state set")
    `DSPC_ASSERT(a_refresh_sec, aclk, aresetn, (adv && res_next.update_display) |=> (st_reg.last_shown_second == $past(in_data_reg.now_second)), "refresh without storing second")
    `DSPC_ASSERT(a_disarmed_zero, aclk, aresetn, !st_reg.armed |-> (st_reg.enter_time == 32'd0), "disarmed policy holds entry time")

endmodule
